[src/fefe_pkg.sv]
// Package for the fire effect frame engine: field widths, stream layout,
// op codes and the 37-entry ARGB heat palette.
// No dependencies.
package fefe_pkg;

  localparam int DEF_FRAME_WIDTH  = 256;
  localparam int DEF_FRAME_HEIGHT = 128;

  localparam int HEAT_W      = 6;
  localparam int COLOR_W     = 32;
  localparam int DRAW_W      = 3;
  localparam int PIX_ADDR_W  = 15;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic [HEAT_W-1:0] MAX_HEAT = 6'd36;
  localparam logic [DRAW_W-1:0] DRAW_MAX = 3'd5;

  localparam logic OP_SPREAD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef logic [HEAT_W-1:0]  heat_t;
  typedef logic [COLOR_W-1:0] color_t;

  function automatic color_t heat_color(input heat_t heat);
    color_t c;
    case (heat)
      6'd0:    c = 32'hFF000000;
      6'd1:    c = 32'hFF070707;
      6'd2:    c = 32'hFF1F0707;
      6'd3:    c = 32'hFF2F0F07;
      6'd4:    c = 32'hFF470F07;
      6'd5:    c = 32'hFF571707;
      6'd6:    c = 32'hFF671F07;
      6'd7:    c = 32'hFF771F07;
      6'd8:    c = 32'hFF8F2707;
      6'd9:    c = 32'hFF9F2F07;
      6'd10:   c = 32'hFFAF3F07;
      6'd11:   c = 32'hFFBF4707;
      6'd12:   c = 32'hFFC74707;
      6'd13:   c = 32'hFFDF4F07;
      6'd14:   c = 32'hFFDF5707;
      6'd15:   c = 32'hFFDF5707;
      6'd16:   c = 32'hFFD75F07;
      6'd17:   c = 32'hFFD7670F;
      6'd18:   c = 32'hFFCF6F0F;
      6'd19:   c = 32'hFFCF770F;
      6'd20:   c = 32'hFFCF7F0F;
      6'd21:   c = 32'hFFCF8717;
      6'd22:   c = 32'hFFC78717;
      6'd23:   c = 32'hFFC78F17;
      6'd24:   c = 32'hFFC7971F;
      6'd25:   c = 32'hFFBF9F1F;
      6'd26:   c = 32'hFFBF9F1F;
      6'd27:   c = 32'hFFBFA727;
      6'd28:   c = 32'hFFBFA727;
      6'd29:   c = 32'hFFBFAF2F;
      6'd30:   c = 32'hFFB7AF2F;
      6'd31:   c = 32'hFFB7B72F;
      6'd32:   c = 32'hFFB7B737;
      6'd33:   c = 32'hFFCFCF6F;
      6'd34:   c = 32'hFFDFDF9F;
      6'd35:   c = 32'hFFEFEFC7;
      6'd36:   c = 32'hFFFFFFFF;
      default: c = 32'h00000000;
    endcase
    return c;
  endfunction

endpackage

[src/fefe_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// The read data holds its value while no read is enabled. No dependencies.
module fefe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/fefe_clear.sv]
// Post-reset sweep that writes the initial frame: zero everywhere and full
// heat along the bottom row. Depends on fefe_pkg.
module fefe_clear
  import fefe_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
  parameter int AW           = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          busy,
  output logic [AW-1:0] wr_addr,
  output heat_t         wr_data
);

  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int BASE   = (FRAME_HEIGHT - 1) * FRAME_WIDTH;

  logic          busy_r, busy_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    if (busy_r) begin
      addr_nxt = addr_r + AW'(1);
      if (addr_r == AW'(PIXELS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign busy    = busy_r;
  assign wr_addr = addr_r;
  assign wr_data = (addr_r >= AW'(BASE)) ? MAX_HEAT : '0;

endmodule

[src/fefe_scan.sv]
// Scan position of the spread walk: columns left to right, source rows from
// the bottom up to row 1, kept as a running linear address. Depends on fefe_pkg.
module fefe_scan
  import fefe_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
  parameter int AW           = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  output logic [AW-1:0] src_addr,
  output logic          frame_end
);

  localparam int BASE = (FRAME_HEIGHT - 1) * FRAME_WIDTH;
  localparam int CW   = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int RW   = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic          row_top, col_last;

  assign row_top  = (row_r == RW'(1));
  assign col_last = (col_r == CW'(FRAME_WIDTH - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    src_nxt = src_r;
    if (advance) begin
      if (row_top) begin
        row_nxt = RW'(FRAME_HEIGHT - 1);
        if (col_last) begin
          col_nxt = '0;
          src_nxt = AW'(BASE);
        end else begin
          col_nxt = col_r + CW'(1);
          src_nxt = AW'(BASE) + AW'(col_r) + AW'(1);
        end
      end else begin
        row_nxt = row_r - RW'(1);
        src_nxt = src_r - AW'(FRAME_WIDTH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= RW'(FRAME_HEIGHT - 1);
      src_r <= AW'(BASE);
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      src_r <= src_nxt;
    end
  end

  assign src_addr  = src_r;
  assign frame_end = row_top & col_last;

endmodule

[src/fire_effect_frame_engine_top.sv]
// Top level of the fire effect frame engine: op sequencer around the frame
// store RAM, with the scan and clearing units. Depends on fefe_pkg, fefe_ram,
// fefe_clear and fefe_scan.
//
//  channel | direction | tdata (lowest bit up)                 | side band
//  in_     | request   | spread_draw[2:0], pixel_addr[17:3]    | tuser = op
//  out_    | result    | color[31:0], intensity[37:32], pad    | tlast = frame_done
//
// Each request runs a frame store read, then the modify, write back and
// loading of the result register.
// After reset a clearing pass writes all FRAME_WIDTH * FRAME_HEIGHT pixels
// (32768 at the defaults); in_tready rises in the cycle after it ends.
// A request is taken while the previous result still waits; the write-back
// cycle then holds until the result register is free.
module fire_effect_frame_engine_top
  import fefe_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // spread_draw[2:0], pixel_addr[17:3], zero pad
  input  logic                   in_tuser,  // op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // color[31:0], intensity[37:32], zero pad
  output logic                   out_tlast
);

  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW     = $clog2(PIXELS);
  localparam int DW     = AW + 2;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              op_r;
  logic [DRAW_W-1:0] draw_r;
  logic              rd_ok_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;

  logic          clr_busy;
  logic [AW-1:0] clr_addr;
  heat_t         clr_data;

  logic          scan_adv;
  logic [AW-1:0] scan_src;
  logic          scan_end;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  heat_t         ram_wdata, ram_rdata;

  logic                  in_accept, can_out, exec_fire;
  logic [DRAW_W-1:0]     in_draw;
  logic [PIX_ADDR_W-1:0] in_pix;
  heat_t                 heat, spread_val, res_heat;
  color_t                res_color;
  logic [DW-1:0]         dst_full;

  assign in_draw = in_tdata[DRAW_W-1:0];
  assign in_pix  = in_tdata[DRAW_W+PIX_ADDR_W-1:DRAW_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid & in_tready;
  assign can_out   = ~out_valid_r | out_tready;
  assign exec_fire = (state_r == ST_EXEC) & can_out;

  fefe_clear #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .AW          (AW)
  ) u_clear (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (clr_busy),
    .wr_addr(clr_addr),
    .wr_data(clr_data)
  );

  assign scan_adv = exec_fire & (op_r == OP_SPREAD);

  fefe_scan #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .AW          (AW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (scan_adv),
    .src_addr (scan_src),
    .frame_end(scan_end)
  );

  assign heat       = (ram_rdata > MAX_HEAT) ? MAX_HEAT : ram_rdata;
  assign spread_val = (heat >= HEAT_W'(draw_r[0])) ? heat - HEAT_W'(draw_r[0]) : '0;
  assign dst_full   = DW'(scan_src) + DW'(2) - DW'(draw_r) - DW'(FRAME_WIDTH);

  assign ram_re    = in_accept;
  assign ram_raddr = (in_tuser == OP_READ) ? AW'(in_pix) : scan_src;
  assign ram_we    = clr_busy | (scan_adv & ~dst_full[DW-1]);
  assign ram_waddr = clr_busy ? clr_addr : dst_full[AW-1:0];
  assign ram_wdata = clr_busy ? clr_data : spread_val;

  fefe_ram #(
    .WIDTH(HEAT_W),
    .DEPTH(PIXELS),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (op_r == OP_READ) begin
      res_heat  = rd_ok_r ? heat : '0;
      res_color = rd_ok_r ? heat_color(heat) : '0;
    end else begin
      res_heat  = spread_val;
      res_color = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (can_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_tuser;
      draw_r  <= (in_draw > DRAW_MAX) ? DRAW_MAX : in_draw;
      rd_ok_r <= (32'(in_pix) < 32'(PIXELS));
    end
    if (exec_fire) begin
      out_data_r <= OUT_TDATA_W'({res_heat, res_color});
      out_last_r <= (op_r == OP_SPREAD) & scan_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
